FILE: sv/sfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sync-header frame deframer.
// No dependencies; imported by the top level and sfd_buf.
package sfd_pkg;

  localparam int unsigned FrameLen = 5;

  localparam logic [7:0] Sync0 = 8'hAA;
  localparam logic [7:0] Sync1 = 8'h55;
  localparam logic [7:0] TypeA = 8'h00;
  localparam logic [7:0] TypeB = 8'hFF;
  localparam logic [7:0] Tail  = 8'hFB;

  localparam logic [15:0] GapReset = 16'd100;

  localparam int unsigned AddrW = 3;
  localparam logic [0:0] RegGapLimit = 1'b0;

  typedef logic [2:0] cnt_t;

  typedef struct packed {
    logic       append;
    logic       restart;
    logic       shift;
    logic       clear;
    logic [7:0] rx_byte;
  } buf_cmd_t;

  typedef struct packed {
    cnt_t       count;
    logic       prefix_ok;
    logic [7:0] type_byte;
    logic [7:0] id_byte;
  } buf_stat_t;

endpackage

FILE: sv/sfd_in_if.sv
`timescale 1ns / 1ps
// Input channel: one received byte with its arrival timestamp.
// Standalone valid/ready interface.
interface sfd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] arrival_ms;

  modport source (output valid, output rx_byte, output arrival_ms, input ready);
  modport sink   (input valid, input rx_byte, input arrival_ms, output ready);
endinterface

FILE: sv/sfd_out_if.sv
`timescale 1ns / 1ps
// Result channel: type and id of a completed frame.
// Standalone valid/ready interface.
interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_type;
  logic [7:0] frame_id;

  modport source (output valid, output frame_type, output frame_id, input ready);
  modport sink   (input valid, input frame_type, input frame_id, output ready);
endinterface

FILE: sv/sync_frame_deframer_with_gap_reset.sv
`timescale 1ns / 1ps
// Top level of the sync-header frame deframer with idle-gap reset.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if and sfd_buf.
//
//   port     dir  handshake            payload
//   in_if    in   valid/ready          rx_byte[8], arrival_ms[32]
//   out_if   out  valid/ready          frame_type[8], frame_id[8]
//   apb      in   psel/penable/pwrite  paddr[3], pwdata/prdata[32] (gap_limit_ms)
//
// Each byte passes accept, gap test and append, then the shift-and-check sequencer,
// which drops one byte per step until the pending bytes form a valid prefix.
// in_if.ready is high only while the sequencer is idle.
// A completed frame waits in the output register; a new byte is taken meanwhile,
// and the sequencer holds only when a second frame completes before the first leaves.
// Synchronous active-low reset clears the buffer count and last arrival, and loads
// the gap limit with its default of 100 ms.
module sync_frame_deframer_with_gap_reset
  import sfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  sfd_in_if.sink           in_if,
  sfd_out_if.source        out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAP,
    ST_CHECK
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] gap_limit_r;
  logic [31:0] last_arrival_r, last_arrival_nxt;
  logic [31:0] arrival_r;
  logic [7:0]  byte_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_type_r, out_type_nxt;
  logic [7:0]  out_id_r, out_id_nxt;
  logic [31:0] elapsed;
  buf_cmd_t    cmd;
  buf_stat_t   st;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegGapLimit) ? {16'b0, gap_limit_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GapReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegGapLimit)) begin
      gap_limit_r <= pwdata[15:0];
    end
  end

  sfd_buf u_buf (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (st)
  );

  assign in_if.ready       = (state_r == ST_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.frame_type = out_type_r;
  assign out_if.frame_id   = out_id_r;

  assign elapsed = arrival_r - last_arrival_r;

  always_comb begin
    state_nxt        = state_r;
    last_arrival_nxt = last_arrival_r;
    out_valid_nxt    = out_valid_r && !out_if.ready;
    out_type_nxt     = out_type_r;
    out_id_nxt       = out_id_r;
    cmd              = '0;
    cmd.rx_byte      = byte_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = ST_GAP;
        end
      end
      ST_GAP: begin
        cmd.append       = 1'b1;
        cmd.restart      = (elapsed > {16'b0, gap_limit_r});
        last_arrival_nxt = arrival_r;
        state_nxt        = ST_CHECK;
      end
      ST_CHECK: begin
        if (!st.prefix_ok) begin
          cmd.shift = 1'b1;
          if (st.count == cnt_t'(1)) begin
            state_nxt = ST_IDLE;
          end
        end else if (st.count == cnt_t'(FrameLen)) begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_nxt = 1'b1;
            out_type_nxt  = st.type_byte;
            out_id_nxt    = st.id_byte;
            cmd.clear     = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      last_arrival_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      last_arrival_r <= last_arrival_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_type_r <= out_type_nxt;
    out_id_r   <= out_id_nxt;
    if (in_if.valid && in_if.ready) begin
      byte_r    <= in_if.rx_byte;
      arrival_r <= in_if.arrival_ms;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.count <= cnt_t'(FrameLen))
    else $error("pending count above frame length");

  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (st.count < cnt_t'(FrameLen)))
    else $error("full buffer left pending while idle");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (st.count == cnt_t'(0)))
    else $error("buffer not cleared on frame emit");

  a_type_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_type_r == TypeA) || (out_type_r == TypeB)))
    else $error("emitted frame type is not a legal type code");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) && !st.prefix_ok |=> !in_if.ready || (st.count == cnt_t'(0)))
    else $error("input accepted with a non-empty invalid prefix");

endmodule

FILE: sv/sfd_buf.sv
`timescale 1ns / 1ps
// Pending byte buffer with one-position shift unit and frame prefix check.
// Depends on sfd_pkg.
module sfd_buf
  import sfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  buf_cmd_t  cmd,
  output buf_stat_t stat
);

  logic [7:0] bytes_r [FrameLen];
  cnt_t       count_r;
  cnt_t       base;

  always_comb begin
    if (cmd.restart || (count_r >= cnt_t'(FrameLen))) begin
      base = '0;
    end else begin
      base = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append) begin
      count_r <= base + cnt_t'(1);
    end else if (cmd.shift) begin
      count_r <= count_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      bytes_r[base] <= cmd.rx_byte;
    end else if (cmd.shift) begin
      for (int i = 0; i < FrameLen - 1; i++) begin
        bytes_r[i] <= bytes_r[i + 1];
      end
      bytes_r[FrameLen - 1] <= '0;
    end
  end

  always_comb begin
    stat.count     = count_r;
    stat.type_byte = bytes_r[2];
    stat.id_byte   = bytes_r[3];
    stat.prefix_ok = 1'b1;
    if ((count_r >= cnt_t'(1)) && (bytes_r[0] != Sync0)) begin
      stat.prefix_ok = 1'b0;
    end
    if ((count_r >= cnt_t'(2)) && (bytes_r[1] != Sync1)) begin
      stat.prefix_ok = 1'b0;
    end
    if ((count_r >= cnt_t'(3)) && (bytes_r[2] != TypeA) && (bytes_r[2] != TypeB)) begin
      stat.prefix_ok = 1'b0;
    end
    if ((count_r >= cnt_t'(5)) && (bytes_r[4] != Tail)) begin
      stat.prefix_ok = 1'b0;
    end
  end

endmodule
